/* rtl/mbru_pkg.sv */
package mbru_pkg;

	localparam int FRAME_BITS     = 8;
	localparam int RUN_FLAG_BIT   = FRAME_BITS - 1;
	localparam int COLOUR_BIT     = FRAME_BITS - 2;
	localparam int LEN_W          = FRAME_BITS - 2;
	localparam int LITERAL_PIXELS = FRAME_BITS - 1;

	typedef logic [FRAME_BITS-1:0]     frame_t;
	typedef logic [LEN_W-1:0]          count_t;
	typedef logic [LITERAL_PIXELS-1:0] pix_shift_t;

	localparam count_t LITERAL_COUNT = count_t'(LITERAL_PIXELS);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture the incoming frame byte
		logic advance;  // current pixel beat taken, step to the next
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic zero_run; // incoming byte is a run of length zero
		logic last;     // pixel on the output is the final one of its byte
	} dp_sts_t;

endpackage

/* rtl/mbru_if.sv */
interface mbru_in_if;
	import mbru_pkg::*;

	logic   valid;
	logic   ready;
	frame_t frame_byte;

	modport source (output valid, output frame_byte, input ready);
	modport sink   (input valid, input frame_byte, output ready);
endinterface

interface mbru_out_if;
	logic valid;
	logic ready;
	logic pixel;
	logic last_of_byte;

	modport source (output valid, output pixel, output last_of_byte, input ready);
	modport sink   (input valid, input pixel, input last_of_byte, output ready);
endinterface

/* rtl/mbru_datapath.sv */
module mbru_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  mbru_pkg::frame_t  frame_byte,
	input  mbru_pkg::dp_cmd_t cmd,
	output mbru_pkg::dp_sts_t sts,
	output logic              pixel,
	output logic              last_of_byte
);
	import mbru_pkg::*;

	pix_shift_t shift_q;
	count_t     remain_q;
	logic       is_run_q;
	logic       is_run_in;

	assign is_run_in = frame_byte[RUN_FLAG_BIT];

	// Run bytes keep the colour in the top bit of the shifter and never shift.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			shift_q  <= frame_byte[LITERAL_PIXELS-1:0];
			is_run_q <= is_run_in;
			remain_q <= is_run_in ? frame_byte[LEN_W-1:0] : LITERAL_COUNT;
		end else if (cmd.advance) begin
			if (!is_run_q) begin
				shift_q <= {shift_q[LITERAL_PIXELS-2:0], 1'b0};
			end
			remain_q <= remain_q - count_t'(1);
		end
	end

	assign pixel        = shift_q[LITERAL_PIXELS-1];
	assign last_of_byte = (remain_q == count_t'(1));

	assign sts.zero_run = is_run_in && (frame_byte[LEN_W-1:0] == '0);
	assign sts.last     = last_of_byte;

	a_adv_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance && !cmd.load |-> remain_q != '0)
		else $error("pixel beat taken with no pixels left");

	a_adv_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance && !cmd.load |=> remain_q == $past(remain_q) - count_t'(1))
		else $error("pixel count did not step down");

endmodule

/* rtl/mbru_ctrl.sv */
module mbru_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output mbru_pkg::dp_cmd_t cmd,
	input  mbru_pkg::dp_sts_t sts
);
	import mbru_pkg::*;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (!sts.zero_run) state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				// next byte may enter on the beat that drains the last pixel
				in_ready  = out_ready && sts.last;
				if (out_ready) begin
					cmd.advance = 1'b1;
					if (sts.last) begin
						if (in_valid) begin
							cmd.load = 1'b1;
							state_d  = sts.zero_run ? ST_IDLE : ST_EMIT;
						end else begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == ST_IDLE) || (out_ready && sts.last))
		else $error("byte loaded while pixels still pending");

	a_mid_byte_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && !sts.last |=> state_q == ST_EMIT)
		else $error("left emit state before last pixel");

	a_zero_run_silent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && sts.zero_run |=> state_q == ST_IDLE)
		else $error("zero-length run produced pixels");

	a_nonzero_emits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && !sts.zero_run |=> state_q == ST_EMIT)
		else $error("byte with pixels did not start emitting");

endmodule

/* rtl/mono_bitmap_rle_unpacker.sv */
// channel  dir  payload                      notes
// frames   in   frame_byte[7:0]              one compressed byte per beat
// pixels   out  pixel, last_of_byte          one pixel per beat
//
// A literal byte gives 7 pixels, a run byte N (N = bits 5..0), one pixel per
// cycle from the shift/count register while pixels is ready; a zero-length
// run gives none. The next byte is taken on the beat that delivers the last
// pixel of the current one. Reset clears only the controller state.
// A stall on pixels holds the current pixel; frames is held off meanwhile.
module mono_bitmap_rle_unpacker (
	input  logic       clk,
	input  logic       arst_n,
	mbru_in_if.sink    frames,
	mbru_out_if.source pixels
);
	import mbru_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	mbru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (frames.valid),
		.in_ready  (frames.ready),
		.out_valid (pixels.valid),
		.out_ready (pixels.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	mbru_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_byte   (frames.frame_byte),
		.cmd          (cmd),
		.sts          (sts),
		.pixel        (pixels.pixel),
		.last_of_byte (pixels.last_of_byte)
	);

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
	import mbru_pkg::*;

	localparam int STALL_LIMIT = 2000;  // cycles with no beat on either channel
	localparam int DRAIN_CYCLES = 80;   // longest run plus pipeline slack

	typedef struct {
		logic pixel;
		logic last_of_byte;
	} pixel_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit idle_en = 1'b1;
	int errors = 0;
	int quiet_cycles = 0;
	pixel_beat_t pending_pixels[$];

	mbru_in_if  frames_if();
	mbru_out_if pixels_if();

	mono_bitmap_rle_unpacker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.frames(frames_if),
		.pixels(pixels_if)
	);

	always #10 clk = ~clk;

	initial begin
		frames_if.valid = 1'b0;
		frames_if.frame_byte = '0;
		pixels_if.ready = 1'b0;
	end

	// pixel sink: drops ready about 37% of the time while idling is on
	always @(posedge clk) begin
		pixels_if.ready <= !idle_en || ($urandom_range(99) >= 37);
	end

	// pixels a frame byte should decode to, oldest first
	function automatic void expand_frame(frame_t b);
		pixel_beat_t beat;
		int run_len;
		if (b[RUN_FLAG_BIT]) begin
			run_len = int'(b[LEN_W-1:0]);
			for (int k = 0; k < run_len; k++) begin
				beat.pixel = b[COLOUR_BIT];
				beat.last_of_byte = (k == run_len - 1);
				pending_pixels.push_back(beat);
			end
		end else begin
			for (int k = 0; k < LITERAL_PIXELS; k++) begin
				beat.pixel = b[LITERAL_PIXELS-1-k];
				beat.last_of_byte = (k == LITERAL_PIXELS - 1);
				pending_pixels.push_back(beat);
			end
		end
	endfunction

	always @(posedge clk) begin
		pixel_beat_t want;
		if (arst_n) begin
			if (frames_if.valid && frames_if.ready)
				expand_frame(frames_if.frame_byte);
			if (pixels_if.valid && pixels_if.ready) begin
				if (pending_pixels.size() == 0) begin
					errors++;
					$display("%0t: unexpected pixel beat, expected none, got pixel=%b last=%b",
						$time, pixels_if.pixel, pixels_if.last_of_byte);
				end else begin
					want = pending_pixels.pop_front();
					if (pixels_if.pixel !== want.pixel ||
						pixels_if.last_of_byte !== want.last_of_byte) begin
						errors++;
						$display("%0t: pixel mismatch, expected pixel=%b last=%b, got pixel=%b last=%b",
							$time, want.pixel, want.last_of_byte,
							pixels_if.pixel, pixels_if.last_of_byte);
					end
				end
			end
			if ((frames_if.valid && frames_if.ready) || (pixels_if.valid && pixels_if.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("tb: failure");
		$finish;
	end

	task automatic send_frame(input frame_t b);
		while (idle_en && $urandom_range(99) < 37) begin
			frames_if.valid <= 1'b0;
			frames_if.frame_byte <= frame_t'($urandom);
			@(posedge clk);
		end
		frames_if.valid <= 1'b1;
		frames_if.frame_byte <= b;
		do @(posedge clk); while (!frames_if.ready);
	endtask

	task automatic test_directed();
		frame_t corner[$] = '{
			8'h00, 8'h7F, 8'h55, 8'h2A, 8'h40, 8'h01,  // literals
			8'h80, 8'hC0,                              // zero-length runs
			8'h81, 8'hC1, 8'hBF, 8'hFF,                // shortest and longest runs
			8'h80, 8'h80, 8'hC0, 8'h3C,                // zero runs back to back, then literal
			8'h9F, 8'hE5, 8'hC0, 8'h81, 8'h7E, 8'h82
		};
		foreach (corner[i])
			send_frame(corner[i]);
	endtask

	task automatic test_random_mix(input int n);
		frame_t b;
		repeat (n) begin
			b = frame_t'($urandom);
			case ($urandom_range(3))
				0: b[RUN_FLAG_BIT] = 1'b0;
				1: begin
					b[RUN_FLAG_BIT] = 1'b1;
					b[LEN_W-1:0] = count_t'($urandom_range(12));
				end
				2: b[RUN_FLAG_BIT] = 1'b1;
				default: ;
			endcase
			send_frame(b);
		end
	endtask

	// full rate on both sides
	task automatic test_no_idle(input int n);
		idle_en = 1'b0;
		test_random_mix(n);
		idle_en = 1'b1;
	endtask

	// zero-length runs mixed in densely with short runs and literals
	task automatic test_zero_runs(input int n);
		frame_t b;
		repeat (n) begin
			b = frame_t'($urandom);
			if ($urandom_range(1)) begin
				b[RUN_FLAG_BIT] = 1'b1;
				b[LEN_W-1:0] = '0;
			end else if ($urandom_range(1)) begin
				b[RUN_FLAG_BIT] = 1'b1;
				b[LEN_W-1:0] = count_t'($urandom_range(1, 3));
			end
			send_frame(b);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(60);
		test_no_idle(40);
		test_zero_runs(30);
		frames_if.valid <= 1'b0;
		// let the checker record the final beat before looking at the queue
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_pixels.size() == 0) begin
			$display("tb: success");
		end else begin
			if (pending_pixels.size() != 0)
				$display("%0t: %0d pixel beats never arrived", $time, pending_pixels.size());
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/mbru_pkg.sv
rtl/mbru_if.sv
rtl/mbru_datapath.sv
rtl/mbru_ctrl.sv
rtl/mono_bitmap_rle_unpacker.sv
dv/tb.sv
